FILE: hw/rtl/tltw_pkg.sv
// shared types and constants of the thick line tile walker
package tltw_pkg;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_NEXT = 1'b1;

    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    // compare request type: probe flag and key
    typedef struct packed {
        logic        probe;
        logic [63:0] key;
    } hist_cmd_t;

endpackage

FILE: hw/rtl/thick_line_tile_walker.sv
// top level of the thick line tile walker
// thick line tile walker: walks a bresenham line with a square brush of
// half-width search_radius and returns the next tile not in the recent window
// input words (s_axis): operation in tuser, endpoints in tdata
//   load (operation 0) is taken in idle and gives no output word
//   next (operation 1) gives one output word: tile, found=1, or found=0 when done
// each brush cell passes S_CELL, which forms the cell, then S_WRAP, which folds
// column and row into the grid by a bit-serial remainder, then S_CMP, which
// compares the key against every history cell at once
// a request passes these states for each brush cell visited, skipped cells included;
// an exhausted or unloaded walk answers from S_CELL without folding or comparing
// history: a chain of HISTORY_DEPTH cells, newest at the head; insertion shifts
// the whole chain by one, cells beyond the window capacity min(5r*r+1, depth)
// are dropped, so eviction is oldest first
// reset clears walk state, window and registers (radius 0, grids 2^COORD_BITS)
// when the receiver stalls, the result stays in the output register and no
// new word is taken until it has gone; input is ready the cycle after
// configuration is over apb; registers at byte addresses 0, 4, 8
module thick_line_tile_walker #(
    parameter int COORD_BITS    = 16,
    parameter int MAX_RADIUS    = 7,
    parameter int HISTORY_DEPTH = 256
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // start_col, start_row, end_col, end_row from the lowest bit up
    input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    // operation
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tile_col, tile_row from the lowest bit up
    output logic [((2*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
    // found
    output logic                  m_axis_tuser,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    localparam int CB   = COORD_BITS;
    localparam int PB   = CB + 2;          // position width, signed room
    localparam int KB   = 2 * CB;
    localparam int HIW  = $clog2(HISTORY_DEPTH + 1);
    localparam int ODW  = ((2*CB+7)/8)*8;
    localparam int CW   = $clog2(CB + 1);
    localparam logic [CB:0] FULL_MOD = {1'b1, {CB{1'b0}}};

    typedef enum logic [2:0] {S_IDLE, S_CELL, S_WRAP, S_CMP, S_OUT} state_t;

    // configuration
    logic [2:0]  radius_reg;
    logic [CB:0] gw_reg, gh_reg;
    logic        wr_en;
    logic [1:0]  wr_idx;
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign wr_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= '0;
            gw_reg     <= FULL_MOD;
            gh_reg     <= FULL_MOD;
        end else if (wr_en) begin
            case (wr_idx)
                tltw_pkg::REG_RADIUS: radius_reg <= pwdata[2:0];
                tltw_pkg::REG_WIDTH:  gw_reg     <= pwdata[CB:0];
                tltw_pkg::REG_HEIGHT: gh_reg     <= pwdata[CB:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (wr_idx)
            tltw_pkg::REG_RADIUS: prdata[2:0]  = radius_reg;
            tltw_pkg::REG_WIDTH:  prdata[CB:0] = gw_reg;
            tltw_pkg::REG_HEIGHT: prdata[CB:0] = gh_reg;
            default: prdata = '0;
        endcase
    end

    // effective radius and modulus
    logic signed [4:0] rad;
    logic [CB:0] mod_w, mod_h;
    logic [HIW:0] cap;
    logic [7:0]   cap_raw;
    always_comb begin
        rad = (radius_reg > 3'(MAX_RADIUS)) ? 5'(MAX_RADIUS) : {2'b00, radius_reg};
        mod_w = (gw_reg == '0 || gw_reg > FULL_MOD) ? FULL_MOD : gw_reg;
        mod_h = (gh_reg == '0 || gh_reg > FULL_MOD) ? FULL_MOD : gh_reg;
        cap_raw = 8'(5 * rad * rad + 1);
        cap = ({1'b0, 8'd0} + (HIW+1)'(cap_raw) > (HIW+1)'(HISTORY_DEPTH)) ?
              (HIW+1)'(HISTORY_DEPTH) : (HIW+1)'(cap_raw);
    end

    // walk state
    state_t state_reg;
    logic   active_reg, steep_reg, neg_reg;
    logic signed [PB-1:0] maj_reg, min_reg, end_reg;
    logic signed [PB:0]   err_reg;
    logic [CB:0]          dmaj_reg, dmin_reg;
    logic signed [4:0]    bmaj_reg, bmin_reg;
    logic [CB-1:0]        col_reg, row_reg;
    logic                 found_reg;

    // load ordering
    logic [CB-1:0] x0, y0, x1, y1, t0, t1;
    logic [CB-1:0] sx0, sy0, sx1, sy1;
    logic [CB-1:0] dx, dy;
    logic          steep;
    always_comb begin
        x0 = s_axis_tdata[CB-1:0];
        y0 = s_axis_tdata[2*CB-1:CB];
        x1 = s_axis_tdata[3*CB-1:2*CB];
        y1 = s_axis_tdata[4*CB-1:3*CB];
        dx = (x1 > x0) ? x1 - x0 : x0 - x1;
        dy = (y1 > y0) ? y1 - y0 : y0 - y1;
        steep = dy > dx;
        t0 = steep ? y0 : x0;
        t1 = steep ? x0 : y0;
        sx1 = steep ? y1 : x1;
        sy1 = steep ? x1 : y1;
        sx0 = t0;
        sy0 = t1;
        if (t0 > sx1) begin
            sx0 = sx1; sy0 = sy1; sx1 = t0; sy1 = t1;
        end
    end

    // current brush cell before wrapping, as magnitude and sign
    logic signed [PB-1:0] ca, cb2, ccol, crow;
    logic [CB:0]          acol, arow;
    always_comb begin
        ca  = maj_reg + PB'(bmaj_reg);
        cb2 = min_reg + PB'(bmin_reg);
        ccol = steep_reg ? cb2 : ca;
        crow = steep_reg ? ca : cb2;
        acol = (ccol < 0) ? (CB+1)'(-ccol) : (CB+1)'(ccol);
        arow = (crow < 0) ? (CB+1)'(-crow) : (CB+1)'(crow);
    end

    // grid fold: restoring remainder, one bit per cycle, column and row together;
    // a negative cell takes the modulus minus the remainder of its magnitude
    logic [CB:0]   ucol_reg, urow_reg;
    logic [CB-1:0] rcol_reg, rrow_reg;
    logic          ncol_reg, nrow_reg;
    logic [CW-1:0] cnt_reg;
    logic [CB:0]   rcol_sh, rrow_sh, rcol_n, rrow_n, wcol, wrow;
    always_comb begin
        rcol_sh = {rcol_reg, ucol_reg[CB]};
        rrow_sh = {rrow_reg, urow_reg[CB]};
        rcol_n  = (rcol_sh >= mod_w) ? rcol_sh - mod_w : rcol_sh;
        rrow_n  = (rrow_sh >= mod_h) ? rrow_sh - mod_h : rrow_sh;
        wcol    = (ncol_reg && rcol_n != '0) ? mod_w - rcol_n : rcol_n;
        wrow    = (nrow_reg && rrow_n != '0) ? mod_h - rrow_n : rrow_n;
    end

    // brush advance
    logic signed [4:0]  bmaj_n, bmin_n;
    logic signed [PB-1:0] maj_n, min_n;
    logic signed [PB:0]   err_n, err_a;
    always_comb begin
        bmaj_n = bmaj_reg;
        bmin_n = bmin_reg + 5'sd1;
        maj_n  = maj_reg;
        min_n  = min_reg;
        err_n  = err_reg;
        err_a  = err_reg + (PB+1)'(dmin_reg);
        if (bmin_n > rad) begin
            bmin_n = -rad;
            bmaj_n = bmaj_reg + 5'sd1;
            if (bmaj_n > rad) begin
                bmaj_n = -rad;
                err_n  = err_a;
                if ((err_a <<< 1) >= $signed((PB+1)'(dmaj_reg))) begin
                    min_n = neg_reg ? min_reg - PB'(1) : min_reg + PB'(1);
                    err_n = err_a - (PB+1)'(dmaj_reg);
                end
                maj_n = maj_reg + PB'(1);
            end
        end
    end

    // history chain
    logic [KB-1:0]          keys   [HISTORY_DEPTH+1];
    logic [HISTORY_DEPTH:0] valids;
    logic [HISTORY_DEPTH-1:0] hits;
    logic                   push;
    logic [KB-1:0]          cur_key;
    assign cur_key   = {row_reg, col_reg};
    assign keys[0]   = cur_key;
    assign valids[0] = 1'b1;

    genvar gi;
    generate
        for (gi = 0; gi < HISTORY_DEPTH; gi++) begin : g_cell
            tltw_hist_cell #(.KEY_BITS(KB)) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .shift_in  (push),
                .key_in    (keys[gi]),
                .valid_in  (valids[gi]),
                .probe_key (cur_key),
                .keep      (!push || (HIW+1)'(gi) < cap),
                .key_out   (keys[gi+1]),
                .valid_out (valids[gi+1]),
                .hit       (hits[gi])
            );
        end
    endgenerate

    logic seen;
    assign seen = |hits;
    assign push = (state_reg == S_CMP) && !seen;

    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && s_axis_tvalid && s_axis_tuser == tltw_pkg::OP_LOAD) begin
            maj_reg  <= PB'(sx0);
            min_reg  <= PB'(sy0);
            end_reg  <= PB'(sx1);
            dmaj_reg <= (CB+1)'(sx1 - sx0);
            dmin_reg <= (sy1 > sy0) ? (CB+1)'(sy1 - sy0) : (CB+1)'(sy0 - sy1);
            neg_reg  <= sy0 > sy1;
            steep_reg <= steep;
            err_reg  <= '0;
            bmaj_reg <= -rad;
            bmin_reg <= -rad;
        end else if (state_reg == S_CELL && active_reg && maj_reg <= end_reg) begin
            ucol_reg <= acol;
            urow_reg <= arow;
            ncol_reg <= ccol < 0;
            nrow_reg <= crow < 0;
            rcol_reg <= '0;
            rrow_reg <= '0;
            cnt_reg  <= CW'(CB);
            bmaj_reg <= bmaj_n;
            bmin_reg <= bmin_n;
            maj_reg  <= maj_n;
            min_reg  <= min_n;
            err_reg  <= err_n;
        end else if (state_reg == S_CELL) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (state_reg == S_WRAP) begin
            ucol_reg <= ucol_reg << 1;
            urow_reg <= urow_reg << 1;
            rcol_reg <= rcol_n[CB-1:0];
            rrow_reg <= rrow_n[CB-1:0];
            cnt_reg  <= cnt_reg - CW'(1);
            if (cnt_reg == '0) begin
                col_reg <= wcol[CB-1:0];
                row_reg <= wrow[CB-1:0];
            end
        end
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            active_reg <= 1'b0;
            found_reg  <= 1'b0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        if (s_axis_tuser == tltw_pkg::OP_LOAD) begin
                            active_reg <= 1'b1;
                        end else begin
                            state_reg <= S_CELL;
                        end
                    end
                end
                S_CELL: begin
                    if (active_reg && maj_reg <= end_reg) begin
                        state_reg <= S_WRAP;
                    end else begin
                        active_reg <= 1'b0;
                        found_reg  <= 1'b0;
                        state_reg  <= S_OUT;
                    end
                end
                S_WRAP: begin
                    if (cnt_reg == '0) state_reg <= S_CMP;
                end
                S_CMP: begin
                    if (seen) begin
                        state_reg <= S_CELL;
                    end else begin
                        found_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_axis_tready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tuser  = found_reg;
    assign m_axis_tdata  = ODW'({row_reg, col_reg});
endmodule

FILE: hw/rtl/tltw_hist_cell.sv
// one history cell: holds a key, shifts towards the tail on insert, compares on probe
module tltw_hist_cell #(
    parameter int KEY_BITS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                shift_in,
    input  logic [KEY_BITS-1:0] key_in,
    input  logic                valid_in,
    input  logic [KEY_BITS-1:0] probe_key,
    input  logic                keep,
    output logic [KEY_BITS-1:0] key_out,
    output logic                valid_out,
    output logic                hit
);
    logic [KEY_BITS-1:0] key_reg;
    logic                valid_reg;
    logic                valid_next;

    always_comb begin
        valid_next = valid_reg;
        if (shift_in) begin
            valid_next = valid_in;
        end
        if (!keep) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_in) begin
            key_reg <= key_in;
        end
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign key_out   = key_reg;
    assign valid_out = valid_reg;
    assign hit       = valid_reg && (key_reg == probe_key);
endmodule

FILE: hw/rtl/tltw_checker.sv
// port-level checks of the thick line tile walker, bound to the top level
module tltw_checker #(
    parameter int COORD_BITS = 16
) (
    input logic aclk,
    input logic aresetn,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic m_axis_tuser,
    input logic [((2*COORD_BITS+7)/8)*8-1:0] m_axis_tdata
);
    a_no_take_while_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !s_axis_tready) else $error("input taken while result pending");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped under stall");
    a_done_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("exhausted result carries a tile");
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid) else $error("result after reset");
endmodule

bind thick_line_tile_walker tltw_checker #(.COORD_BITS(COORD_BITS)) u_tltw_checker (
    .aclk(aclk), .aresetn(aresetn), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tuser(m_axis_tuser),
    .m_axis_tdata(m_axis_tdata));

FILE: tb/tb_top.sv
// self-checking testbench of the thick line tile walker
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = 16;
    localparam int DEPTH = 256;
    localparam int RMAX = 7;
    localparam int N_RANDOM = 1750;
    localparam longint CYCLE_LIMIT = 10000000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;   // start_col, start_row, end_col, end_row from bit 0 up
    logic        s_axis_tuser = 1'b0; // operation
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // tile_col, tile_row from bit 0 up
    logic        m_axis_tuser;        // found
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    thick_line_tile_walker dut (.*);

    // clock: 10 ns period
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    typedef struct packed {
        logic [15:0] col;
        logic [15:0] row;
        logic        found;
    } tile_t;

    // predictor state, our own copy of the block
    int unsigned     radius_reg;
    int unsigned     width_reg, height_reg;
    bit              walking, steep, minor_neg;
    longint          maj_pos, min_pos, maj_end, maj_d, min_d, err_acc;
    int              off_maj, off_min;
    longint unsigned window_key[DEPTH];
    int unsigned     window_cnt, window_oldest;

    tile_t           expected_tiles[$];
    int              fail_count = 0;
    longint          cycle_count = 0;
    bit              stall_enable = 1'b0;
    bit              long_hold = 1'b0;
    bit              quiet_stretch = 1'b0;

    function automatic int radius_now();
        return (radius_reg > RMAX) ? RMAX : int'(radius_reg);
    endfunction

    function automatic longint modulus(int unsigned r);
        return (r == 0 || r > (1 << CB)) ? longint'(1 << CB) : longint'(r);
    endfunction

    function automatic longint fold(longint v, longint m);
        longint q;
        q = v % m;
        if (q < 0) q += m;
        return q;
    endfunction

    function automatic bit window_holds(longint unsigned k);
        for (int i = 0; i < window_cnt; i++)
            if (window_key[(window_oldest + i) % DEPTH] == k) return 1'b1;
        return 1'b0;
    endfunction

    function automatic void window_add(longint unsigned k);
        int unsigned cap;
        cap = 5 * radius_now() * radius_now() + 1;
        if (cap > DEPTH) cap = DEPTH;
        while (window_cnt >= cap) begin
            window_oldest = (window_oldest + 1) % DEPTH;
            window_cnt--;
        end
        window_key[(window_oldest + window_cnt) % DEPTH] = k;
        window_cnt++;
    endfunction

    function automatic void brush_step();
        int r;
        r = radius_now();
        off_min++;
        if (off_min > r) begin
            off_min = -r;
            off_maj++;
            if (off_maj > r) begin
                off_maj = -r;
                err_acc += min_d;
                if (2 * err_acc >= maj_d) begin
                    min_pos += minor_neg ? -1 : 1;
                    err_acc -= maj_d;
                end
                maj_pos++;
            end
        end
    endfunction

    // models one accepted word; returns 1 with the tile when a result is due
    function automatic bit walk_tile(logic op, logic [63:0] d, output tile_t t);
        longint x0, y0, x1, y1, dx, dy, tmp, a, b, c, rw;
        longint unsigned k;
        t = '0;
        if (op == tltw_pkg::OP_LOAD) begin
            x0 = d[15:0]; y0 = d[31:16]; x1 = d[47:32]; y1 = d[63:48];
            dx = (x1 > x0) ? x1 - x0 : x0 - x1;
            dy = (y1 > y0) ? y1 - y0 : y0 - y1;
            steep = dy > dx;
            if (steep) begin
                tmp = x0; x0 = y0; y0 = tmp;
                tmp = x1; x1 = y1; y1 = tmp;
            end
            if (x0 > x1) begin
                tmp = x0; x0 = x1; x1 = tmp;
                tmp = y0; y0 = y1; y1 = tmp;
            end
            maj_pos = x0; min_pos = y0; maj_end = x1;
            maj_d = x1 - x0;
            min_d = (y1 > y0) ? y1 - y0 : y0 - y1;
            minor_neg = y0 > y1;
            err_acc = 0;
            off_maj = -radius_now();
            off_min = -radius_now();
            walking = 1'b1;
            return 1'b0;
        end
        while (walking) begin
            if (maj_pos > maj_end) begin
                walking = 1'b0;
                break;
            end
            a = maj_pos + off_maj;
            b = min_pos + off_min;
            if (steep) begin c = b; rw = a; end
            else begin c = a; rw = b; end
            brush_step();
            c = fold(c, modulus(width_reg));
            rw = fold(rw, modulus(height_reg));
            k = (longint'(rw) << CB) | longint'(c);
            if (window_holds(k)) continue;
            window_add(k);
            t.col = c[15:0];
            t.row = rw[15:0];
            t.found = 1'b1;
            return 1'b1;
        end
        return 1'b1;
    endfunction

    // cycle limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off in its own process
    always @(negedge aclk) begin
        if (!stall_enable || quiet_stretch) m_axis_tready <= !long_hold && aresetn;
        else m_axis_tready <= !long_hold && ($urandom_range(99) >= 26);
    end

    initial begin
        wait (stall_enable);
        repeat (3000) @(posedge aclk);
        long_hold = 1'b1;
        repeat (400) @(posedge aclk);
        long_hold = 1'b0;
    end

    // result checker: compares each word with the oldest expected tile
    always @(posedge aclk) begin
        tile_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_tiles.size() == 0) begin
                $error("unexpected result word col=%0d row=%0d found=%0b",
                       m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tuser);
                fail_count++;
            end else begin
                want = expected_tiles[0];
                expected_tiles.delete(0);
                if (m_axis_tdata[15:0] !== want.col) begin
                    $error("tile_col expected %0d got %0d", want.col, m_axis_tdata[15:0]);
                    fail_count++;
                end
                if (m_axis_tdata[31:16] !== want.row) begin
                    $error("tile_row expected %0d got %0d", want.row, m_axis_tdata[31:16]);
                    fail_count++;
                end
                if (m_axis_tuser !== want.found) begin
                    $error("found expected %0b got %0b", want.found, m_axis_tuser);
                    fail_count++;
                end
            end
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        @(negedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            tltw_pkg::REG_RADIUS: radius_reg = val & 32'h7;
            tltw_pkg::REG_WIDTH:  width_reg = val & 32'h1ffff;
            default:              height_reg = val & 32'h1ffff;
        endcase
    endtask

    // offers one word, waits for acceptance; pred marks rows checked by the predictor
    // tvalid stays up after acceptance so the next word can follow without a gap
    task automatic send_word(logic op, logic [63:0] d, bit pred = 1'b1,
                             tile_t typed = '0);
        tile_t t;
        bit due;
        @(negedge aclk);
        while (stall_enable && !quiet_stretch && $urandom_range(99) < 26) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= d;
        do @(posedge aclk); while (!s_axis_tready);
        due = walk_tile(op, d, t);
        if (due) expected_tiles.push_back(pred ? t : typed);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (expected_tiles.size() != 0) @(posedge aclk);
        // a load or a skipped cell may still be in flight
        repeat (40) @(posedge aclk);
    endtask

    function automatic logic [63:0] seg(int c0, int r0, int c1, int r1);
        return {r1[15:0], c1[15:0], r0[15:0], c0[15:0]};
    endfunction

    typedef struct {
        logic        op;
        logic [63:0] d;
        bit          pred;
        tile_t       typed;
    } row_t;

    row_t directed[$];

    function automatic row_t mk(logic op, logic [63:0] d, bit pred = 1'b1,
                                tile_t typed = '0);
        row_t r;
        r.op = op; r.d = d; r.pred = pred; r.typed = typed;
        return r;
    endfunction

    logic [15:0] sc, sr;
    int          seg_len, reqs;

    initial begin
        radius_reg = 0; width_reg = 1 << CB; height_reg = 1 << CB;
        walking = 0; steep = 0; minor_neg = 0;
        maj_pos = 0; min_pos = 0; maj_end = 0; maj_d = 0; min_d = 0; err_acc = 0;
        off_maj = 0; off_min = 0; window_cnt = 0; window_oldest = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed table: request with no segment, extremes, steep, reversed, point
        directed.push_back(mk(tltw_pkg::OP_NEXT, '1, 1'b0, '{16'd0, 16'd0, 1'b0}));
        directed.push_back(mk(tltw_pkg::OP_LOAD, seg(0, 0, 0, 0)));
        directed.push_back(mk(tltw_pkg::OP_NEXT, '0, 1'b0, '{16'd0, 16'd0, 1'b1}));
        directed.push_back(mk(tltw_pkg::OP_NEXT, '0, 1'b0, '{16'd0, 16'd0, 1'b0}));
        directed.push_back(mk(tltw_pkg::OP_NEXT, '0, 1'b0, '{16'd0, 16'd0, 1'b0}));
        directed.push_back(mk(tltw_pkg::OP_LOAD, seg(65535, 65535, 65532, 65535)));
        for (int i = 0; i < 5; i++) directed.push_back(mk(tltw_pkg::OP_NEXT, '0));
        directed.push_back(mk(tltw_pkg::OP_LOAD, seg(10, 20, 12, 14)));
        for (int i = 0; i < 8; i++) directed.push_back(mk(tltw_pkg::OP_NEXT, '1));
        directed.push_back(mk(tltw_pkg::OP_LOAD, seg(5, 5, 9, 7)));
        directed.push_back(mk(tltw_pkg::OP_LOAD, seg(65535, 0, 0, 65535)));
        for (int i = 0; i < 3; i++) directed.push_back(mk(tltw_pkg::OP_NEXT, '0));
        foreach (directed[i])
            send_word(directed[i].op, directed[i].d, directed[i].pred, directed[i].typed);
        drain();

        // largest radius, a small grid and out-of-range grid values: wrap
        reg_write(tltw_pkg::REG_RADIUS, 32'd7);
        reg_write(tltw_pkg::REG_WIDTH, 32'd8);
        reg_write(tltw_pkg::REG_HEIGHT, 32'd8);
        send_word(tltw_pkg::OP_LOAD, seg(6, 1, 9, 3));
        for (int i = 0; i < 20; i++) send_word(tltw_pkg::OP_NEXT, '0);
        drain();
        reg_write(tltw_pkg::REG_WIDTH, 32'h1ffff);
        reg_write(tltw_pkg::REG_HEIGHT, 32'd0);
        send_word(tltw_pkg::OP_LOAD, seg(0, 65535, 1, 65534));
        for (int i = 0; i < 10; i++) send_word(tltw_pkg::OP_NEXT, '0);
        drain();

        stall_enable = 1'b1;
        // random phases with changing settings
        for (int phase = 0; phase < 6; phase++) begin
            quiet_stretch = (phase == 2);
            case (phase)
                0: begin reg_write(tltw_pkg::REG_RADIUS, 32'd1);
                         reg_write(tltw_pkg::REG_WIDTH, 32'd65536);
                         reg_write(tltw_pkg::REG_HEIGHT, 32'd65536); end
                1: begin reg_write(tltw_pkg::REG_RADIUS, 32'd0);
                         reg_write(tltw_pkg::REG_WIDTH, 32'd8);
                         reg_write(tltw_pkg::REG_HEIGHT, 32'd13); end
                2: begin reg_write(tltw_pkg::REG_RADIUS, 32'd2);
                         reg_write(tltw_pkg::REG_WIDTH, $urandom_range(8, 200));
                         reg_write(tltw_pkg::REG_HEIGHT, $urandom_range(8, 200)); end
                3: begin reg_write(tltw_pkg::REG_RADIUS, 32'd7);
                         reg_write(tltw_pkg::REG_WIDTH, 32'd65536);
                         reg_write(tltw_pkg::REG_HEIGHT, 32'd8); end
                4: begin reg_write(tltw_pkg::REG_RADIUS, $urandom_range(0, 7));
                         reg_write(tltw_pkg::REG_WIDTH, $urandom_range(8, 65536));
                         reg_write(tltw_pkg::REG_HEIGHT, $urandom_range(8, 65536)); end
                default: begin reg_write(tltw_pkg::REG_RADIUS, 32'd3);
                         reg_write(tltw_pkg::REG_WIDTH, 32'd20);
                         reg_write(tltw_pkg::REG_HEIGHT, 32'd65536); end
            endcase
            for (int n = 0; n < N_RANDOM / 6; ) begin
                if ($urandom_range(9) == 0) begin
                    // noise: arbitrary word
                    send_word(1'($urandom_range(1)), {$urandom, $urandom});
                    n++;
                end else begin
                    // short segment near a random point, then a random run of requests on it
                    sc = 16'($urandom); sr = 16'($urandom);
                    seg_len = $urandom_range(0, 6);
                    send_word(tltw_pkg::OP_LOAD, seg(sc, sr,
                        (sc + $urandom_range(0, 2 * seg_len) - seg_len) & 16'hffff,
                        (sr + $urandom_range(0, 2 * seg_len) - seg_len) & 16'hffff));
                    reqs = (radius_reg > 2) ? $urandom_range(1, 12) : $urandom_range(1, 25);
                    for (int k = 0; k < reqs; k++)
                        send_word(tltw_pkg::OP_NEXT, {$urandom, $urandom});
                    n += reqs + 1;
                end
            end
            drain();
        end
        quiet_stretch = 1'b0;

        drain();
        if (fail_count == 0 && expected_tiles.size() == 0) begin
            $display("simulation ok");
        end else begin
            if (expected_tiles.size() != 0)
                $error("%0d expected results never arrived", expected_tiles.size());
            $display("simulation failed");
        end
        $finish;
    end
endmodule

FILE: thick_line_tile_walker.f
hw/rtl/tltw_pkg.sv
hw/rtl/tltw_hist_cell.sv
hw/rtl/thick_line_tile_walker.sv
hw/rtl/tltw_checker.sv
tb/tb_top.sv
